>>> sv/lz4bd_pkg.sv
// Shared types and constants for the LZ4 block decompressor.
// No dependencies.
package lz4bd_pkg;

    localparam int HISTORY_DEPTH_DEF = 65536;
    localparam int DRAIN_BURST_DEF   = 63;
    localparam int LEN_WIDTH_DEF     = 24;

    localparam logic [1:0] K_DATA   = 2'd0;
    localparam logic [1:0] K_DONE   = 2'd1;
    localparam logic [1:0] K_ERROR  = 2'd2;
    localparam logic [1:0] K_REFUSE = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_TRUNC  = 2'd1;
    localparam logic [1:0] ST_BADOFF = 2'd2;
    localparam logic [1:0] ST_OVER   = 2'd3;

    localparam logic CMD_BYTE  = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    localparam logic [23:0] CAP_RESET = 24'hFF_FFFF;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data;
        logic       last;
    } t_item;

endpackage

>>> sv/lz4bd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lz4bd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> sv/lz4bd_front.sv
// Front end: accepts input transactions into a two-entry queue.
// Depends on lz4bd_pkg.
module lz4bd_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  lz4bd_pkg::t_item i_item,
    output logic             o_stall,
    output logic             o_item_valid,
    output lz4bd_pkg::t_item o_item,
    input  logic             i_pop
);
    import lz4bd_pkg::*;

    t_item      r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    assign o_stall      = (r_cnt == 2'd2);
    assign o_item_valid = (r_cnt != 2'd0);
    assign o_item       = r_mem[r_rp];
    assign w_push       = i_valid && !o_stall;
    assign w_pop        = i_pop && o_item_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_item;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule

>>> sv/lz4bd_back.sv
// Back end: token/length/offset parsing, history RAM and match copy, result register.
// Depends on lz4bd_pkg and lz4bd_ram.
module lz4bd_back #(
    parameter int HISTORY_DEPTH = lz4bd_pkg::HISTORY_DEPTH_DEF,
    parameter int DRAIN_BURST   = lz4bd_pkg::DRAIN_BURST_DEF,
    parameter int LEN_WIDTH     = lz4bd_pkg::LEN_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_item_valid,
    input  lz4bd_pkg::t_item i_item,
    output logic             o_item_pop,
    input  logic [23:0]      i_out_capacity,
    input  logic             i_out_stall,
    output logic             o_out_valid,
    output logic [1:0]       o_kind,
    output logic [7:0]       o_out_data,
    output logic [1:0]       o_status,
    output logic [23:0]      o_total_len,
    output logic             o_copy_pending,
    output logic             o_last
);
    import lz4bd_pkg::*;

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int CW = ((LEN_WIDTH > 24) ? LEN_WIDTH : 24) + 1;
    localparam int KW = $clog2(DRAIN_BURST + 1);
    localparam logic [CW-1:0] LMASK  = CW'({LEN_WIDTH{1'b1}});
    localparam logic [KW-1:0] K_LAST = KW'(DRAIN_BURST - 1);

    typedef enum logic [2:0] {
        PH_TOKEN, PH_LITEXT, PH_LITERAL, PH_OFFLO, PH_OFFHI, PH_MATEXT, PH_COPY, PH_HALT
    } t_phase;
    typedef enum logic [1:0] {SQ_IDLE, SQ_RD, SQ_WR, SQ_HALT} t_seq;

    t_phase               r_phase, n_phase;
    t_seq                 r_seq, n_seq;
    logic [LEN_WIDTH-1:0] r_count, n_count, r_lit, n_lit, r_mrem, n_mrem;
    logic [15:0]          r_off, n_off;
    logic [3:0]           r_nib, n_nib;
    logic                 r_final, n_final;
    logic [1:0]           r_hcode, n_hcode;
    logic [KW-1:0]        r_k, n_k;

    logic                 r_out_valid, n_out_valid;
    logic [1:0]           r_kind, n_kind, r_status, n_status;
    logic [7:0]           r_data, n_data;
    logic [23:0]          r_total, n_total;
    logic                 r_cp, n_cp, r_last, n_last;

    logic                 w_out_free, w_emit, w_h_do, w_we, w_re;
    logic [1:0]           w_h_code, w_e_kind;
    logic [7:0]           w_e_data, w_wdata, w_rdata, w_b;
    logic                 w_e_last, w_lb;
    logic [CW-1:0]        w_lim, w_sum, w_cnt_x;
    logic [AW-1:0]        w_waddr, w_raddr;

    function automatic logic fits(input logic [CW-1:0] len, input logic [CW-1:0] lim,
                                  input logic [CW-1:0] cnt);
        return (len <= lim) && (cnt <= lim - len);
    endfunction

    lz4bd_ram #(.WIDTH(8), .DEPTH(HISTORY_DEPTH)) u_hist (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_re   (w_re),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign w_lim      = (CW'(i_out_capacity) < LMASK) ? CW'(i_out_capacity) : LMASK;
    assign w_cnt_x    = CW'(r_count);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_waddr    = r_count[AW-1:0];
    assign w_raddr    = AW'(r_count - LEN_WIDTH'(r_off));
    assign w_b        = i_item.data;
    assign w_lb       = i_item.last;

    always_comb begin
        n_phase = r_phase;  n_seq = r_seq;    n_count = r_count; n_lit = r_lit;
        n_mrem  = r_mrem;   n_off = r_off;    n_nib = r_nib;     n_final = r_final;
        n_hcode = r_hcode;  n_k = r_k;
        o_item_pop = 1'b0;
        w_emit = 1'b0; w_e_kind = K_DATA; w_e_data = 8'd0; w_e_last = 1'b0;
        w_h_do = 1'b0; w_h_code = ST_OK;
        w_we = 1'b0; w_wdata = w_b; w_re = 1'b0;
        w_sum = '0;

        case (r_seq)
            SQ_IDLE: begin
                if (i_item_valid && w_out_free) begin
                    o_item_pop = 1'b1;
                    if (r_phase == PH_HALT) begin
                        w_h_do = 1'b1; w_h_code = r_hcode;
                    end else if (i_item.cmd == CMD_DRAIN) begin
                        if (r_phase == PH_COPY) begin
                            n_seq = SQ_RD; n_k = '0;
                        end
                    end else if (r_phase == PH_COPY) begin
                        w_emit = 1'b1; w_e_kind = K_REFUSE; w_e_last = 1'b1;
                    end else begin
                        case (r_phase)
                            PH_TOKEN: begin
                                n_nib = w_b[3:0];
                                if (w_b[7:4] == 4'd15) begin
                                    n_lit = LEN_WIDTH'(15);
                                    if (w_lb) begin
                                        w_h_do = 1'b1; w_h_code = ST_TRUNC;
                                    end else n_phase = PH_LITEXT;
                                end else if (w_b[7:4] == 4'd0) begin
                                    n_lit = '0;
                                    if (w_lb) w_h_do = 1'b1;
                                    else n_phase = PH_OFFLO;
                                end else if (w_lb) begin
                                    w_h_do = 1'b1; w_h_code = ST_TRUNC;
                                end else if (!fits(CW'(w_b[7:4]), w_lim, w_cnt_x)) begin
                                    w_h_do = 1'b1; w_h_code = ST_OVER;
                                end else begin
                                    n_lit = LEN_WIDTH'(w_b[7:4]); n_phase = PH_LITERAL;
                                end
                            end
                            PH_LITEXT: begin
                                w_sum = CW'(r_lit) + CW'(w_b);
                                n_lit = LEN_WIDTH'(w_sum);
                                if (w_lb) begin
                                    w_h_do = 1'b1; w_h_code = ST_TRUNC;
                                end else if (w_sum > LMASK) begin
                                    w_h_do = 1'b1; w_h_code = ST_OVER;
                                end else if (w_b != 8'd255) begin
                                    if (!fits(w_sum, w_lim, w_cnt_x)) begin
                                        w_h_do = 1'b1; w_h_code = ST_OVER;
                                    end else n_phase = PH_LITERAL;
                                end
                            end
                            PH_LITERAL: begin
                                w_we = 1'b1;
                                n_count = r_count + 1'b1;
                                if (r_lit != '0) n_lit = r_lit - 1'b1;
                                if (n_lit == '0) n_phase = PH_OFFLO;
                                w_emit = 1'b1; w_e_data = w_b;
                                if (w_lb) begin
                                    n_phase = PH_HALT;
                                    n_hcode = (n_lit == '0) ? ST_OK : ST_TRUNC;
                                    n_seq   = SQ_HALT;
                                end else w_e_last = 1'b1;
                            end
                            PH_OFFLO: begin
                                n_off = {8'd0, w_b};
                                if (w_lb) begin
                                    w_h_do = 1'b1; w_h_code = ST_TRUNC;
                                end else n_phase = PH_OFFHI;
                            end
                            PH_OFFHI: begin
                                n_off  = {w_b, r_off[7:0]};
                                n_mrem = LEN_WIDTH'(r_nib) + LEN_WIDTH'(4);
                                if (n_off == 16'd0 || LEN_WIDTH'(n_off) > r_count) begin
                                    w_h_do = 1'b1; w_h_code = ST_BADOFF;
                                end else if (r_nib == 4'd15) begin
                                    if (w_lb) begin
                                        w_h_do = 1'b1; w_h_code = ST_TRUNC;
                                    end else n_phase = PH_MATEXT;
                                end else if (!fits(CW'(n_mrem), w_lim, w_cnt_x)) begin
                                    w_h_do = 1'b1; w_h_code = ST_OVER;
                                end else begin
                                    n_phase = PH_COPY; n_final = w_lb;
                                end
                            end
                            PH_MATEXT: begin
                                w_sum  = CW'(r_mrem) + CW'(w_b);
                                n_mrem = LEN_WIDTH'(w_sum);
                                if (w_b == 8'd255 && w_lb) begin
                                    w_h_do = 1'b1; w_h_code = ST_TRUNC;
                                end else if (w_sum > LMASK) begin
                                    w_h_do = 1'b1; w_h_code = w_lb ? ST_TRUNC : ST_OVER;
                                end else if (w_b != 8'd255) begin
                                    if (!fits(w_sum, w_lim, w_cnt_x)) begin
                                        w_h_do = 1'b1; w_h_code = ST_OVER;
                                    end else begin
                                        n_phase = PH_COPY; n_final = w_lb;
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            end
            SQ_RD: begin
                w_re  = 1'b1;
                n_seq = SQ_WR;
            end
            SQ_WR: begin
                if (w_out_free) begin
                    w_we = 1'b1; w_wdata = w_rdata;
                    n_count = r_count + 1'b1;
                    if (r_mrem != '0) n_mrem = r_mrem - 1'b1;
                    n_k = r_k + 1'b1;
                    w_emit = 1'b1; w_e_data = w_rdata;
                    if (n_mrem == '0) begin
                        if (r_final) begin
                            n_phase = PH_HALT; n_hcode = ST_OK; n_seq = SQ_HALT;
                        end else begin
                            n_phase = PH_TOKEN; w_e_last = 1'b1; n_seq = SQ_IDLE;
                        end
                    end else if (r_k == K_LAST) begin
                        w_e_last = 1'b1; n_seq = SQ_IDLE;
                    end else n_seq = SQ_RD;
                end
            end
            SQ_HALT: begin
                if (w_out_free) begin
                    w_h_do = 1'b1; w_h_code = r_hcode; n_seq = SQ_IDLE;
                end
            end
            default: n_seq = SQ_IDLE;
        endcase

        if (w_h_do) begin
            n_phase  = PH_HALT;
            n_hcode  = w_h_code;
            w_emit   = 1'b1;
            w_e_kind = (w_h_code == ST_OK) ? K_DONE : K_ERROR;
            w_e_data = 8'd0;
            w_e_last = 1'b1;
        end

        n_out_valid = r_out_valid && i_out_stall;
        n_kind = r_kind; n_data = r_data; n_status = r_status;
        n_total = r_total; n_cp = r_cp; n_last = r_last;
        if (w_emit) begin
            n_out_valid = 1'b1;
            n_kind      = w_e_kind;
            n_data      = w_e_data;
            n_status    = (w_e_kind == K_ERROR) ? n_hcode : ST_OK;
            n_total     = 24'(CW'(n_count));
            n_cp        = (n_phase == PH_COPY);
            n_last      = w_e_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind; r_data <= n_data; r_status <= n_status;
        r_total <= n_total; r_cp <= n_cp; r_last <= n_last;
        r_off <= n_off; r_nib <= n_nib; r_k <= n_k;
        if (!i_rst_n) begin
            r_phase     <= PH_TOKEN;
            r_seq       <= SQ_IDLE;
            r_count     <= '0;
            r_lit       <= '0;
            r_mrem      <= '0;
            r_final     <= 1'b0;
            r_hcode     <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_seq       <= n_seq;
            r_count     <= n_count;
            r_lit       <= n_lit;
            r_mrem      <= n_mrem;
            r_final     <= n_final;
            r_hcode     <= n_hcode;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_kind;
    assign o_out_data     = r_data;
    assign o_status       = r_status;
    assign o_total_len    = r_total;
    assign o_copy_pending = r_cp;
    assign o_last         = r_last;
endmodule

>>> sv/lz4_block_decompressor_core.sv
// LZ4 block decompressor top level: APB capacity register, input queue, decode engine.
// A result is registered at the edge that takes its transaction from the queue; a final
// literal adds a done or truncation error result from the halt state.
// Throughput: one compressed byte per cycle while the output is free and no match copy runs;
// a drain transaction is taken from the queue, then each copied byte is a history RAM read,
// then a write and output, up to DRAIN_BURST bytes per drain transaction.
// Synchronous active-low reset clears control state; history RAM is not cleared.
// Depends on lz4bd_pkg, lz4bd_front, lz4bd_back, lz4bd_ram.
module lz4_block_decompressor_core #(
    parameter int HISTORY_DEPTH = lz4bd_pkg::HISTORY_DEPTH_DEF,
    parameter int DRAIN_BURST   = lz4bd_pkg::DRAIN_BURST_DEF,
    parameter int LEN_WIDTH     = lz4bd_pkg::LEN_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_cmd,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_out_data,
    output logic [1:0]  o_status,
    output logic [23:0] o_total_len,
    output logic        o_copy_pending,
    output logic        o_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lz4bd_pkg::*;

    logic [23:0] r_out_capacity;
    t_item       w_in_item, w_q_item;
    logic        w_q_valid, w_q_pop;

    assign pready = 1'b1;
    assign prdata = {8'd0, r_out_capacity};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_capacity <= CAP_RESET;
        end else if (psel && penable && pwrite && paddr == 1'b0) begin
            r_out_capacity <= pwdata[23:0];
        end
    end

    assign w_in_item = '{cmd: i_cmd, data: i_data_byte, last: i_last_byte};

    lz4bd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .i_item      (w_in_item),
        .o_stall     (o_in_stall),
        .o_item_valid(w_q_valid),
        .o_item      (w_q_item),
        .i_pop       (w_q_pop)
    );

    lz4bd_back #(
        .HISTORY_DEPTH(HISTORY_DEPTH),
        .DRAIN_BURST  (DRAIN_BURST),
        .LEN_WIDTH    (LEN_WIDTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item_valid  (w_q_valid),
        .i_item        (w_q_item),
        .o_item_pop    (w_q_pop),
        .i_out_capacity(r_out_capacity),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_kind        (o_kind),
        .o_out_data    (o_out_data),
        .o_status      (o_status),
        .o_total_len   (o_total_len),
        .o_copy_pending(o_copy_pending),
        .o_last        (o_last)
    );
endmodule

>>> tb/sv/testbench.sv
// Testbench for lz4_block_decompressor_core: streams one long LZ4 block with random
// sequences, predicts every result transaction and checks it field by field.
// Depends on lz4bd_pkg and the decompressor RTL.
module testbench;
    import lz4bd_pkg::*;

    localparam longint LEN_MASK   = 64'hFF_FFFF;
    localparam int     BURST      = 63;
    localparam longint CYCLE_CAP  = 3000000;

    typedef enum logic [2:0] {
        PH_TOKEN, PH_LITEXT, PH_LITERAL, PH_OFFLO, PH_OFFHI, PH_MATEXT, PH_COPY, PH_HALT
    } dec_phase_e;

    typedef struct {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic [1:0]  status;
        logic [23:0] total;
        logic        pending;
        logic        last;
    } result_t;

    class decomp_scoreboard;
        bit [7:0]   hist [65536];
        longint     cap, count, lit_rem, match_rem;
        bit [15:0]  offs;
        bit [3:0]   mnib;
        bit         final_seen;
        bit [1:0]   halt_st;
        dec_phase_e ph;
        result_t    expq[$];
        result_t    burst[$];
        int         errors, checked, items;

        function new();
            cap = longint'(CAP_RESET);
            ph = PH_TOKEN;
        endfunction

        function void set_capacity(logic [23:0] v);
            cap = longint'(v);
        endfunction

        task report(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        function void emit(logic [1:0] kind, logic [7:0] data, logic [1:0] st);
            result_t r;
            r.kind = kind;
            r.data = data;
            r.status = st;
            r.total = count[23:0];
            r.pending = (ph == PH_COPY);
            r.last = 0;
            burst.push_back(r);
        endfunction

        function void emit_halt();
            if (halt_st == ST_OK) emit(K_DONE, 8'd0, ST_OK);
            else emit(K_ERROR, 8'd0, halt_st);
        endfunction

        function void halt(logic [1:0] code);
            ph = PH_HALT;
            halt_st = code;
            emit_halt();
        endfunction

        function bit fits(longint len);
            longint c;
            c = (cap < LEN_MASK) ? cap : LEN_MASK;
            return len <= c && count <= c - len;
        endfunction

        function void put_byte(bit [7:0] v);
            hist[count[15:0]] = v;
            count = (count + 1) & LEN_MASK;
        endfunction

        function void start_match(bit lastb);
            if (!fits(match_rem)) begin
                halt(ST_OVER);
                return;
            end
            ph = PH_COPY;
            final_seen = lastb;
        endfunction

        function void take_byte(bit [7:0] b, bit lastb);
            longint lit;
            case (ph)
                PH_TOKEN: begin
                    lit = longint'(b[7:4]);
                    mnib = b[3:0];
                    if (lit == 15) begin
                        lit_rem = 15;
                        if (lastb) halt(ST_TRUNC);
                        else ph = PH_LITEXT;
                    end else if (lit == 0) begin
                        lit_rem = 0;
                        if (lastb) halt(ST_OK);
                        else ph = PH_OFFLO;
                    end else if (lastb) begin
                        halt(ST_TRUNC);
                    end else if (!fits(lit)) begin
                        halt(ST_OVER);
                    end else begin
                        lit_rem = lit;
                        ph = PH_LITERAL;
                    end
                end
                PH_LITEXT: begin
                    if (lastb) begin
                        halt(ST_TRUNC);
                        return;
                    end
                    lit_rem += longint'(b);
                    if (lit_rem > LEN_MASK) halt(ST_OVER);
                    else if (b != 255) begin
                        if (!fits(lit_rem)) halt(ST_OVER);
                        else ph = PH_LITERAL;
                    end
                end
                PH_LITERAL: begin
                    put_byte(b);
                    if (lit_rem > 0) lit_rem--;
                    if (lit_rem == 0) ph = PH_OFFLO;
                    emit(K_DATA, b, ST_OK);
                    if (lastb) halt(lit_rem == 0 ? ST_OK : ST_TRUNC);
                end
                PH_OFFLO: begin
                    offs = {8'd0, b};
                    if (lastb) halt(ST_TRUNC);
                    else ph = PH_OFFHI;
                end
                PH_OFFHI: begin
                    offs[15:8] = b;
                    if (offs == 0 || longint'(offs) > count) begin
                        halt(ST_BADOFF);
                        return;
                    end
                    match_rem = longint'(mnib) + 4;
                    if (mnib == 15) begin
                        if (lastb) halt(ST_TRUNC);
                        else ph = PH_MATEXT;
                    end else begin
                        start_match(lastb);
                    end
                end
                PH_MATEXT: begin
                    if (b == 255 && lastb) begin
                        halt(ST_TRUNC);
                        return;
                    end
                    match_rem += longint'(b);
                    if (match_rem > LEN_MASK) halt(lastb ? ST_TRUNC : ST_OVER);
                    else if (b != 255) start_match(lastb);
                end
                default: ;
            endcase
        endfunction

        function void drain();
            bit [7:0] v;
            for (int k = 0; k < BURST && ph == PH_COPY; k++) begin
                v = hist[count[15:0] - offs];
                put_byte(v);
                if (match_rem > 0) match_rem--;
                if (match_rem == 0) ph = final_seen ? PH_HALT : PH_TOKEN;
                emit(K_DATA, v, ST_OK);
            end
            if (ph == PH_HALT) begin
                halt_st = ST_OK;
                emit_halt();
            end
        endfunction

        function void note_item(logic cmd, logic [7:0] b, logic lastb);
            items++;
            burst.delete();
            if (ph == PH_HALT) emit_halt();
            else if (cmd == CMD_DRAIN) begin
                if (ph == PH_COPY) drain();
            end else if (ph == PH_COPY) emit(K_REFUSE, 8'd0, ST_OK);
            else take_byte(b, lastb);
            if (burst.size() > 0) burst[burst.size() - 1].last = 1;
            foreach (burst[i]) expq.push_back(burst[i]);
        endfunction

        task check_result(result_t got);
            result_t e;
            checked++;
            if (expq.size() == 0) begin
                report($sformatf("unexpected result kind=%0d", got.kind));
                return;
            end
            e = expq.pop_front();
            if (got.kind !== e.kind)
                report($sformatf("#%0d kind %0d exp %0d", checked, got.kind, e.kind));
            if (got.data !== e.data)
                report($sformatf("#%0d data %h exp %h", checked, got.data, e.data));
            if (got.status !== e.status)
                report($sformatf("#%0d status %0d exp %0d", checked, got.status, e.status));
            if (got.total !== e.total)
                report($sformatf("#%0d total_len %0d exp %0d", checked, got.total, e.total));
            if (got.pending !== e.pending)
                report($sformatf("#%0d copy_pending %0d exp %0d", checked, got.pending,
                                 e.pending));
            if (got.last !== e.last)
                report($sformatf("#%0d last %0d exp %0d", checked, got.last, e.last));
        endtask
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_in_valid = 0;
    logic        o_in_stall;
    logic        i_cmd = 0;
    logic [7:0]  i_data_byte = 0;
    logic        i_last_byte = 0;
    logic        o_out_valid;
    logic        i_out_stall = 0;
    logic [1:0]  o_kind;
    logic [7:0]  o_out_data;
    logic [1:0]  o_status;
    logic [23:0] o_total_len;
    logic        o_copy_pending;
    logic        o_last;
    logic        psel = 0;
    logic        penable = 0;
    logic        pwrite = 0;
    logic [0:0]  paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic        pready;

    decomp_scoreboard sb = new();
    longint cycles = 0;
    longint gen_count = 0;

    lz4_block_decompressor_core dut (.*);

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        result_t r;
        if (i_rst_n && i_in_valid && !o_in_stall)
            sb.note_item(i_cmd, i_data_byte, i_last_byte);
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            r.kind = o_kind;
            r.data = o_out_data;
            r.status = o_status;
            r.total = o_total_len;
            r.pending = o_copy_pending;
            r.last = o_last;
            sb.check_result(r);
        end
    end

    // receiver: random stalls, one long hold-off to back the block up
    initial begin
        int r, n;
        bit held;
        logic v;
        held = 0;
        @(posedge i_rst_n);
        forever begin
            r = $urandom_range(0, 99);
            if (!held && cycles > 3000) begin
                v = 1;
                n = 800;
                held = 1;
            end else if (r < 45) begin
                v = 0;
                n = $urandom_range(1, 20);
            end else if (r < 95) begin
                v = 1;
                n = $urandom_range(1, 3);
            end else begin
                v = 1;
                n = $urandom_range(20, 60);
            end
            i_out_stall <= v;
            repeat (n) @(posedge i_clk);
        end
    end

    task automatic send(logic cmd, logic [7:0] b, logic lastb);
        int r, gap;
        i_in_valid <= 1;
        i_cmd <= cmd;
        i_data_byte <= b;
        i_last_byte <= lastb;
        do @(posedge i_clk); while (o_in_stall);
        r = $urandom_range(0, 99);
        gap = (r < 70) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        if (gap > 0) begin
            i_in_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_byte(logic [7:0] b);
        send(CMD_BYTE, b, 0);
    endtask

    task automatic send_len_ext(int rem);
        while (rem >= 255) begin
            send_byte(8'd255);
            rem -= 255;
        end
        send_byte(rem[7:0]);
    endtask

    task automatic drain_match(int len);
        int rem;
        rem = len;
        while (rem > 0) begin
            if ($urandom_range(0, 9) == 0) send(CMD_BYTE, 8'($urandom), 1'($urandom));
            send(CMD_DRAIN, 8'($urandom), 1'($urandom));
            rem -= BURST;
        end
        if ($urandom_range(0, 7) == 0) send(CMD_DRAIN, 8'($urandom), 1'($urandom));
        gen_count += len;
    endtask

    task automatic send_sequence(bit grow);
        int r, lit, m, off, hi_lim;
        logic [3:0] hi, lo;
        r = $urandom_range(0, 99);
        if (grow) lit = $urandom_range(1, 8);
        else if (r < 15) lit = 0;
        else if (r < 30) lit = $urandom_range(15, 300);
        else lit = $urandom_range(1, 14);
        r = $urandom_range(0, 99);
        if (grow) m = 19 + 255 * $urandom_range(6, 12) + $urandom_range(0, 254);
        else if (r < 70) m = $urandom_range(4, 18);
        else m = $urandom_range(19, 600);
        hi = (lit >= 15) ? 4'd15 : lit[3:0];
        lo = (m - 4 >= 15) ? 4'd15 : 4'(m - 4);
        send_byte({hi, lo});
        if (lit >= 15) send_len_ext(lit - 15);
        repeat (lit) send_byte(8'($urandom));
        gen_count += lit;
        hi_lim = (gen_count > 65535) ? 65535 : int'(gen_count);
        if ($urandom_range(0, 99) < 30) off = $urandom_range(1, hi_lim < 4 ? hi_lim : 4);
        else off = $urandom_range(1, hi_lim);
        send_byte(off[7:0]);
        send_byte(off[15:8]);
        if (m >= 19) send_len_ext(m - 19);
        drain_match(m);
    endtask

    task automatic write_capacity(logic [23:0] v);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= 0;
        pwdata <= {8'd0, v};
        @(posedge i_clk);
        penable <= 1;
        do @(posedge i_clk); while (!pready);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        sb.set_capacity(v);
    endtask

    task automatic wait_idle();
        i_in_valid <= 0;
        @(posedge i_clk);
        while (sb.expq.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    initial begin
        int pick;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        write_capacity(CAP_RESET);

        // extended literal run with extreme bytes, overlapping match, refused byte,
        // idle drain, then zero-literal token with chained match length
        send_byte(8'hF0);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'hFF);
        repeat (13) send_byte(8'($urandom));
        gen_count = 15;
        send_byte(8'h01);
        send_byte(8'h00);
        send(CMD_BYTE, 8'hAA, 1);
        send(CMD_DRAIN, 8'h55, 1);
        send(CMD_DRAIN, 8'h00, 0);
        gen_count += 4;
        send_byte(8'h0F);
        send_byte(8'h10);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h00);
        drain_match(274);
        wait_idle();

        write_capacity(24'($urandom_range(24'h10_0000, 24'hFF_FFFE)));
        repeat (4) send_sequence(1);
        while (sb.items < 240) send_sequence(0);
        wait_idle();
        write_capacity(CAP_RESET);
        while (sb.items < 470) send_sequence(0);
        wait_idle();

        // zero capacity, then end the block as done, truncated, bad offset or overflow
        write_capacity(24'd0);
        pick = $urandom_range(0, 3);
        case (pick)
            0: send(CMD_BYTE, {4'd0, 4'($urandom)}, 1);
            1: send(CMD_BYTE, {4'd15, 4'($urandom)}, 1);
            2: begin
                send_byte(8'h00);
                send_byte(8'h00);
                send_byte(8'h00);
            end
            default: send_byte(8'h10);
        endcase
        repeat (6) send(1'($urandom), 8'($urandom), 1'($urandom));
        i_in_valid <= 0;
        @(posedge i_clk);
        while (sb.expq.size() > 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        if (sb.expq.size() > 0)
            sb.report($sformatf("%0d expected results never arrived", sb.expq.size()));
        $display("Run: %0d input transactions, %0d result transactions checked,",
                 sb.items, sb.checked);
        $display("     %0d bytes decompressed, block ending case %0d.", sb.count, pick);
        if (sb.errors == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end
endmodule
